// File: rtl/hsfd_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants for the humidity sensor frame decoder
// no dependencies; used by every other file of the block

package hsfd_pkg;

    localparam int CFG_W        = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int FRAME_BYTES  = 5;
    localparam int FRAME_BITS   = 8 * FRAME_BYTES;
    localparam int BIT_IDX_W    = 6;
    localparam int FIELD_W      = 16;
    localparam int CAPTURE_BITS = 16;

    localparam logic [CFG_W-1:0] RESPONSE_NOMINAL_RST = 10'd80;
    localparam logic [CFG_W-1:0] BYTE_START_LOW_RST   = 10'd60;
    localparam logic [CFG_W-1:0] BIT_START_LOW_RST    = 10'd50;
    localparam logic [CFG_W-1:0] ZERO_HIGH_RST        = 10'd26;
    localparam logic [CFG_W-1:0] ONE_HIGH_RST         = 10'd70;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESPONSE_NOMINAL = 3'd0,
        REG_BYTE_START_LOW   = 3'd1,
        REG_BIT_START_LOW    = 3'd2,
        REG_ZERO_HIGH        = 3'd3,
        REG_ONE_HIGH         = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_CAPTURE = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_NORESP   = 3'd2,
        ST_DECODE   = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_RESPONSE = 3'b010,
        PH_BITS     = 3'b100
    } phase_t;

endpackage

// File: rtl/hsfd_channels.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for capture input and reading output
// depends on hsfd_pkg for field widths

interface hsfd_capture_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [hsfd_pkg::FIELD_W-1:0]  low_width;
    logic [hsfd_pkg::FIELD_W-1:0]  cycle_width;

    modport source (output valid, mode, low_width, cycle_width, input ready);
    modport sink   (input valid, mode, low_width, cycle_width, output ready);
endinterface

interface hsfd_reading_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          status;
    logic [hsfd_pkg::FIELD_W-1:0]        humidity;
    logic signed [hsfd_pkg::FIELD_W-1:0] temperature;

    modport source (output valid, status, humidity, temperature, input ready);
    modport sink   (input valid, status, humidity, temperature, output ready);
endinterface

// File: rtl/hsfd_pulse_check.sv
`timescale 1ns / 1ps
// tolerance window check of one pulse: low and high width against nominal +/- half
// depends on hsfd_pkg for the register width

module hsfd_pulse_check #(
    parameter int CW = 16
) (
    input  logic [CW-1:0]                 low_width,
    input  logic [CW-1:0]                 cycle_width,
    input  logic [hsfd_pkg::CFG_W-1:0]    nom_low,
    input  logic [hsfd_pkg::CFG_W-1:0]    nom_high,
    output logic                          ok
);
    localparam int XW = ((CW > hsfd_pkg::CFG_W) ? CW : hsfd_pkg::CFG_W) + 2;

    logic [CW:0]   high_diff;
    logic          high_neg;
    logic [XW-1:0] lo_x;
    logic [XW-1:0] hi_x;
    logic [XW-1:0] lo_min;
    logic [XW-1:0] lo_max;
    logic [XW-1:0] hi_min;
    logic [XW-1:0] hi_max;

    // high = period - low; borrow means negative, which fails every window
    assign high_diff = {1'b0, cycle_width} - {1'b0, low_width};
    assign high_neg  = high_diff[CW];

    assign lo_x = XW'(low_width);
    assign hi_x = XW'(high_diff[CW-1:0]);

    assign lo_min = XW'(nom_low)  - XW'(nom_low  >> 1);
    assign lo_max = XW'(nom_low)  + XW'(nom_low  >> 1);
    assign hi_min = XW'(nom_high) - XW'(nom_high >> 1);
    assign hi_max = XW'(nom_high) + XW'(nom_high >> 1);

    assign ok = !high_neg
             && (lo_x >= lo_min) && (lo_x < lo_max)
             && (hi_x >= hi_min) && (hi_x < hi_max);
endmodule

// File: rtl/humidity_sensor_frame_decoder_core.sv
`timescale 1ns / 1ps
// top level of the single-wire humidity sensor frame decoder
// depends on hsfd_pkg, hsfd_channels and hsfd_pulse_check
//
//  channel   dir  payload                               handshake
//  capture   in   mode, low_width, cycle_width          valid/ready
//  reading   out  status, humidity, temperature         valid/ready
//  cfg       in   cfg_index, cfg_data                   cfg_we, no stall
//
// one capture per cycle while capture.ready is high; reading.valid rises
// after a frame-ending capture: input register, decode, result register
// reset loads the default nominals and leaves the decoder idle
// capture.ready drops only while the input register and the result register
// both hold data and reading.ready is low

module humidity_sensor_frame_decoder_core #(
    parameter int CAPTURE_BITS = hsfd_pkg::CAPTURE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hsfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hsfd_pkg::CFG_W-1:0]          cfg_data,
    hsfd_capture_if.sink                        capture,
    hsfd_reading_if.source                      reading
);
    localparam int CW = (CAPTURE_BITS < hsfd_pkg::FIELD_W) ? CAPTURE_BITS
                                                           : hsfd_pkg::FIELD_W;
    localparam int FB = hsfd_pkg::FRAME_BITS;

    // configuration
    logic [hsfd_pkg::CFG_W-1:0] response_nominal_reg;
    logic [hsfd_pkg::CFG_W-1:0] byte_start_low_reg;
    logic [hsfd_pkg::CFG_W-1:0] bit_start_low_reg;
    logic [hsfd_pkg::CFG_W-1:0] zero_high_reg;
    logic [hsfd_pkg::CFG_W-1:0] one_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            response_nominal_reg <= hsfd_pkg::RESPONSE_NOMINAL_RST;
            byte_start_low_reg   <= hsfd_pkg::BYTE_START_LOW_RST;
            bit_start_low_reg    <= hsfd_pkg::BIT_START_LOW_RST;
            zero_high_reg        <= hsfd_pkg::ZERO_HIGH_RST;
            one_high_reg         <= hsfd_pkg::ONE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (hsfd_pkg::cfg_reg_t'(cfg_index))
                hsfd_pkg::REG_RESPONSE_NOMINAL: response_nominal_reg <= cfg_data;
                hsfd_pkg::REG_BYTE_START_LOW:   byte_start_low_reg   <= cfg_data;
                hsfd_pkg::REG_BIT_START_LOW:    bit_start_low_reg    <= cfg_data;
                hsfd_pkg::REG_ZERO_HIGH:        zero_high_reg        <= cfg_data;
                hsfd_pkg::REG_ONE_HIGH:         one_high_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic                 in_valid_reg;
    hsfd_pkg::mode_t      in_mode_reg;
    logic [CW-1:0]        in_low_reg;
    logic [CW-1:0]        in_cycle_reg;
    logic                 advance;

    logic                 out_valid_reg;
    logic                 out_valid_next;

    assign advance       = !out_valid_reg || reading.ready;
    assign capture.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (capture.ready)
            in_valid_reg <= capture.valid;
    end

    always_ff @(posedge clk)
    begin
        if (capture.valid && capture.ready)
        begin
            in_mode_reg  <= hsfd_pkg::mode_t'(capture.mode);
            in_low_reg   <= capture.low_width[CW-1:0];
            in_cycle_reg <= capture.cycle_width[CW-1:0];
        end
    end

    // decoder state
    hsfd_pkg::phase_t              phase_reg;
    hsfd_pkg::phase_t              phase_next;
    logic [hsfd_pkg::BIT_IDX_W-1:0] bit_index_reg;
    logic [hsfd_pkg::BIT_IDX_W-1:0] bit_index_next;
    logic [FB-1:0]                 frame_bits_reg;
    logic [FB-1:0]                 frame_bits_next;

    logic                          fire;
    logic [hsfd_pkg::CFG_W-1:0]    nom_low;
    logic                          resp_ok;
    logic                          one_ok;
    logic                          zero_ok;

    assign fire = in_valid_reg && advance;

    // byte start: first bit of every byte after the first
    assign nom_low = ((bit_index_reg != '0) && (bit_index_reg[2:0] == 3'd0))
                   ? byte_start_low_reg : bit_start_low_reg;

    hsfd_pulse_check #(.CW(CW)) u_resp_check (
        .low_width   (in_low_reg),
        .cycle_width (in_cycle_reg),
        .nom_low     (response_nominal_reg),
        .nom_high    (response_nominal_reg),
        .ok          (resp_ok)
    );

    hsfd_pulse_check #(.CW(CW)) u_one_check (
        .low_width   (in_low_reg),
        .cycle_width (in_cycle_reg),
        .nom_low     (nom_low),
        .nom_high    (one_high_reg),
        .ok          (one_ok)
    );

    hsfd_pulse_check #(.CW(CW)) u_zero_check (
        .low_width   (in_low_reg),
        .cycle_width (in_cycle_reg),
        .nom_low     (nom_low),
        .nom_high    (zero_high_reg),
        .ok          (zero_ok)
    );

    // frame assembly and checksum on the frame including this bit
    logic [FB-1:0]                  shifted_bits;
    logic [hsfd_pkg::BIT_IDX_W-1:0] index_inc;
    logic [7:0]                     byte_sum;
    logic [7:0]                     b0;
    logic [7:0]                     b1;
    logic [7:0]                     b2;
    logic [7:0]                     b3;
    logic [7:0]                     b4;
    logic [15:0]                    raw_temp;
    logic [15:0]                    dec_hum;
    logic [15:0]                    dec_temp;

    assign shifted_bits = {frame_bits_reg[FB-2:0], one_ok};
    assign index_inc    = bit_index_reg + hsfd_pkg::BIT_IDX_W'(1);

    assign b0 = shifted_bits[FB-1 -: 8];
    assign b1 = shifted_bits[FB-9 -: 8];
    assign b2 = shifted_bits[FB-17 -: 8];
    assign b3 = shifted_bits[FB-25 -: 8];
    assign b4 = shifted_bits[FB-33 -: 8];

    always_comb
    begin
        byte_sum = '0;
        for (int i = 0; i < hsfd_pkg::FRAME_BYTES - 1; i++)
            byte_sum = byte_sum + shifted_bits[FB-1-8*i -: 8];
    end

    assign raw_temp = {b2, b3};

    always_comb
    begin
        if ((b1 == 8'd0) && (b3 == 8'd0))
        begin
            // 8-bit sensor frame
            dec_hum  = {8'd0, b0};
            dec_temp = {8'd0, b2};
        end
        else
        begin
            dec_hum  = {b0, b1};
            dec_temp = raw_temp[15] ? (16'd0 - {1'b0, raw_temp[14:0]}) : raw_temp;
        end
    end

    // per-transaction control
    logic                    emit;
    hsfd_pkg::status_t       emit_status;
    logic [15:0]             emit_hum;
    logic [15:0]             emit_temp;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        frame_bits_next = frame_bits_reg;
        emit            = 1'b0;
        emit_status     = hsfd_pkg::ST_OK;
        emit_hum        = '0;
        emit_temp       = '0;

        if (fire)
        begin
            unique case (in_mode_reg)
                hsfd_pkg::MODE_START:
                begin
                    phase_next      = hsfd_pkg::PH_RESPONSE;
                    bit_index_next  = '0;
                    frame_bits_next = '0;
                end
                hsfd_pkg::MODE_NONE: ;
                hsfd_pkg::MODE_TIMEOUT:
                begin
                    if (phase_reg != hsfd_pkg::PH_IDLE)
                    begin
                        emit        = 1'b1;
                        emit_status = hsfd_pkg::ST_TIMEOUT;
                        phase_next  = hsfd_pkg::PH_IDLE;
                    end
                end
                hsfd_pkg::MODE_CAPTURE:
                begin
                    unique case (phase_reg)
                        hsfd_pkg::PH_IDLE: ;
                        hsfd_pkg::PH_RESPONSE:
                        begin
                            priority if (in_cycle_reg == '0)
                            begin
                                emit        = 1'b1;
                                emit_status = hsfd_pkg::ST_NORESP;
                                phase_next  = hsfd_pkg::PH_IDLE;
                            end
                            else if (!resp_ok)
                            begin
                                emit        = 1'b1;
                                emit_status = hsfd_pkg::ST_DECODE;
                                phase_next  = hsfd_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next      = hsfd_pkg::PH_BITS;
                                bit_index_next  = '0;
                                frame_bits_next = '0;
                            end
                        end
                        hsfd_pkg::PH_BITS:
                        begin
                            if (!one_ok && !zero_ok)
                            begin
                                emit        = 1'b1;
                                emit_status = hsfd_pkg::ST_DECODE;
                                phase_next  = hsfd_pkg::PH_IDLE;
                            end
                            else
                            begin
                                frame_bits_next = shifted_bits;
                                bit_index_next  = index_inc;
                                if (index_inc == hsfd_pkg::BIT_IDX_W'(FB))
                                begin
                                    emit       = 1'b1;
                                    phase_next = hsfd_pkg::PH_IDLE;
                                    if (byte_sum != b4)
                                        emit_status = hsfd_pkg::ST_CHECKSUM;
                                    else
                                    begin
                                        emit_status = hsfd_pkg::ST_OK;
                                        emit_hum    = dec_hum;
                                        emit_temp   = dec_temp;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hsfd_pkg::PH_IDLE;
            bit_index_reg  <= '0;
            frame_bits_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            frame_bits_reg <= frame_bits_next;
        end
    end

    // result register
    logic [2:0]  out_status_reg;
    logic [15:0] out_hum_reg;
    logic [15:0] out_temp_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !reading.ready;
        if (fire)
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_status_reg <= emit_status;
            out_hum_reg    <= emit_hum;
            out_temp_reg   <= emit_temp;
        end
    end

    assign reading.valid       = out_valid_reg;
    assign reading.status      = out_status_reg;
    assign reading.humidity    = out_hum_reg;
    assign reading.temperature = $signed(out_temp_reg);
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for humidity_sensor_frame_decoder_core
// random frames of captures against an in-bench decoder model
// depends on hsfd_pkg and hsfd_channels

module tb;

    typedef struct {
        hsfd_pkg::mode_t mode;
        logic [15:0]     lo;
        logic [15:0]     cyc;
    } capture_t;

    typedef struct {
        hsfd_pkg::status_t  status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } reading_t;

    typedef enum {
        FR_GOOD, FR_BAD_SUM, FR_BAD_BIT, FR_TIMEOUT,
        FR_NO_RESP, FR_BAD_RESP, FR_RESTART, FR_NOISE
    } frame_kind_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [hsfd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hsfd_pkg::CFG_W-1:0]     cfg_data;

    hsfd_capture_if cap ();
    hsfd_reading_if rdg ();

    humidity_sensor_frame_decoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .capture   (cap),
        .reading   (rdg)
    );

    capture_t capture_q[$];
    reading_t reading_q[$];
    int       items_queued;
    int       readings_seen;
    int       mismatches;
    bit       cap_taken;
    int       holds_asked;
    int       holds_served;

    // nominal widths as currently programmed
    int nom[5];

    // decoder model state
    hsfd_pkg::phase_t dec_phase;
    int               dec_bits;
    logic [39:0]      dec_frame;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic bit in_range(int x, int n);
        return x >= n - n / 2 && x < n + n / 2;
    endfunction

    function automatic int low_nominal(int idx);
        return (idx != 0 && idx % 8 == 0) ? nom[hsfd_pkg::REG_BYTE_START_LOW]
                                          : nom[hsfd_pkg::REG_BIT_START_LOW];
    endfunction

    task automatic decode_capture(input capture_t c, output bit fired, output reading_t r);
        int          lo;
        int          hi;
        int          nlo;
        bit          ok;
        bit          b;
        logic [7:0]  b0, b1, b2, b3, b4;
        logic [7:0]  sum;
        logic [15:0] raw;
        fired = 1'b0;
        r.status = hsfd_pkg::ST_OK;
        r.humidity = '0;
        r.temperature = '0;
        lo = int'(c.lo);
        hi = int'(c.cyc) - lo;
        if (c.mode == hsfd_pkg::MODE_START)
        begin
            dec_phase = hsfd_pkg::PH_RESPONSE;
            dec_bits = 0;
            dec_frame = '0;
        end
        else if (dec_phase == hsfd_pkg::PH_IDLE || c.mode == hsfd_pkg::MODE_NONE)
        begin
        end
        else if (c.mode == hsfd_pkg::MODE_TIMEOUT)
        begin
            fired = 1'b1;
            r.status = hsfd_pkg::ST_TIMEOUT;
        end
        else if (dec_phase == hsfd_pkg::PH_RESPONSE)
        begin
            if (c.cyc == 0)
            begin
                fired = 1'b1;
                r.status = hsfd_pkg::ST_NORESP;
            end
            else if (!(in_range(lo, nom[hsfd_pkg::REG_RESPONSE_NOMINAL])
                       && in_range(hi, nom[hsfd_pkg::REG_RESPONSE_NOMINAL])))
            begin
                fired = 1'b1;
                r.status = hsfd_pkg::ST_DECODE;
            end
            else
            begin
                dec_phase = hsfd_pkg::PH_BITS;
                dec_bits = 0;
                dec_frame = '0;
            end
        end
        else
        begin
            nlo = low_nominal(dec_bits);
            ok = 1'b1;
            b = 1'b0;
            // the one window takes priority where both match
            if (in_range(lo, nlo) && in_range(hi, nom[hsfd_pkg::REG_ONE_HIGH]))
                b = 1'b1;
            else if (!(in_range(lo, nlo) && in_range(hi, nom[hsfd_pkg::REG_ZERO_HIGH])))
                ok = 1'b0;
            if (!ok)
            begin
                fired = 1'b1;
                r.status = hsfd_pkg::ST_DECODE;
            end
            else
            begin
                dec_frame = {dec_frame[38:0], b};
                dec_bits++;
                if (dec_bits == hsfd_pkg::FRAME_BITS)
                begin
                    fired = 1'b1;
                    {b0, b1, b2, b3, b4} = dec_frame;
                    sum = b0 + b1 + b2 + b3;
                    if (sum != b4)
                        r.status = hsfd_pkg::ST_CHECKSUM;
                    else if (b1 == 0 && b3 == 0)
                    begin
                        r.humidity = {8'd0, b0};
                        r.temperature = {8'd0, b2};
                    end
                    else
                    begin
                        raw = {b2, b3};
                        r.humidity = {b0, b1};
                        r.temperature = raw[15] ? -{1'b0, raw[14:0]} : raw;
                    end
                end
            end
        end
        if (fired)
            dec_phase = hsfd_pkg::PH_IDLE;
    endtask

    // capture driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : drive_blk
        capture_t nxt;
        if (rst_n && (!cap.valid || cap_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                cap.valid <= 1'b0;
            end
            else if (capture_q.size() > 0)
            begin
                nxt = capture_q.pop_front();
                cap.valid <= 1'b1;
                cap.mode <= nxt.mode;
                cap.low_width <= nxt.lo;
                cap.cycle_width <= nxt.cyc;
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(3, 0) == 0)
                begin
                    gap_left = 0;
                    burst_left = $urandom_range(60, 20);
                end
                else
                begin
                    gap_left = $urandom_range(8, 1);
                    burst_left = $urandom_range(10, 0);
                end
            end
            else
                cap.valid <= 1'b0;
        end
    end

    // reading receiver: own stall pattern plus requested long holds
    int hold_cnt = 0;
    int pat = 0;
    int pat_left = 0;

    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rdg.ready <= 1'b0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served++;
            hold_cnt = 400;
            rdg.ready <= 1'b0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat = $urandom_range(3, 0);
                pat_left = $urandom_range(80, 10);
            end
            pat_left--;
            case (pat)
                0:       rdg.ready <= 1'b1;
                1:       rdg.ready <= 1'($urandom_range(1, 0));
                2:       rdg.ready <= ($urandom_range(3, 0) != 0);
                default: rdg.ready <= ($urandom_range(7, 0) == 0);
            endcase
        end
    end

    // monitor: predict on each capture transaction, check each reading transaction
    always @(posedge clk)
    begin : check_blk
        capture_t c;
        reading_t want;
        bit       fired;
        if (!rst_n)
            cap_taken = 1'b0;
        else
        begin
            cap_taken = cap.valid && cap.ready;
            if (cap_taken)
            begin
                c.mode = hsfd_pkg::mode_t'(cap.mode);
                c.lo = cap.low_width;
                c.cyc = cap.cycle_width;
                decode_capture(c, fired, want);
                if (fired)
                    reading_q.push_back(want);
            end
            if (rdg.valid && rdg.ready)
            begin
                readings_seen++;
                if (reading_q.size() == 0)
                begin
                    $error("unexpected reading: status %0d humidity %0d temperature %0d",
                           rdg.status, rdg.humidity, rdg.temperature);
                    mismatches++;
                end
                else
                begin
                    want = reading_q.pop_front();
                    if (rdg.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rdg.status);
                        mismatches++;
                    end
                    if (rdg.humidity !== want.humidity)
                    begin
                        $error("humidity: expected %0d, got %0d", want.humidity, rdg.humidity);
                        mismatches++;
                    end
                    if (rdg.temperature !== want.temperature)
                    begin
                        $error("temperature: expected %0d, got %0d",
                               want.temperature, rdg.temperature);
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic int pick_in(int n);
        int lo_b;
        int hi_b;
        int r;
        lo_b = n - n / 2;
        hi_b = n + n / 2;
        r = $urandom_range(9, 0);
        if (hi_b <= lo_b)
            return $urandom_range(3 * n + 3, 0);
        if (r == 0)
            return lo_b;
        if (r == 1)
            return hi_b - 1;
        return $urandom_range(hi_b - 1, lo_b);
    endfunction

    function automatic int pick_out(int n);
        int r;
        r = $urandom_range(3, 0);
        if (r == 0)
            return n + n / 2;
        if (r == 1 && n - n / 2 > 0)
            return n - n / 2 - 1;
        if (r == 2)
            return $urandom_range(65535, 0);
        return n + n / 2 + $urandom_range(50, 0);
    endfunction

    task automatic queue_capture(hsfd_pkg::mode_t m, int lo, int cyc, bit counted);
        capture_t c;
        c.mode = m;
        c.lo = 16'(lo);
        c.cyc = 16'(cyc);
        capture_q.push_back(c);
        if (counted)
            items_queued++;
    endtask

    task automatic queue_response(bit good);
        int lo;
        int n;
        n = nom[hsfd_pkg::REG_RESPONSE_NOMINAL];
        lo = good ? pick_in(n) : pick_out(n);
        queue_capture(hsfd_pkg::MODE_CAPTURE, lo, lo + pick_in(n), 1'b1);
    endtask

    task automatic queue_bit(int idx, bit b);
        int lo;
        lo = pick_in(low_nominal(idx));
        queue_capture(hsfd_pkg::MODE_CAPTURE, lo,
                      lo + pick_in(b ? nom[hsfd_pkg::REG_ONE_HIGH]
                                     : nom[hsfd_pkg::REG_ZERO_HIGH]), 1'b1);
    endtask

    task automatic queue_bad_bit(int idx);
        int lo;
        int cyc;
        int wide;
        wide = (nom[hsfd_pkg::REG_ONE_HIGH] > nom[hsfd_pkg::REG_ZERO_HIGH])
             ? nom[hsfd_pkg::REG_ONE_HIGH] : nom[hsfd_pkg::REG_ZERO_HIGH];
        case ($urandom_range(3, 0))
            0:
            begin
                lo = pick_in(low_nominal(idx));
                cyc = 0;
            end
            1:
            begin
                lo = $urandom_range(65535, 1);
                cyc = $urandom_range(lo - 1, 0);
            end
            2:
            begin
                lo = pick_out(low_nominal(idx));
                cyc = lo + pick_in(nom[hsfd_pkg::REG_ONE_HIGH]);
            end
            default:
            begin
                lo = pick_in(low_nominal(idx));
                cyc = lo + 2 * wide + 1;
            end
        endcase
        queue_capture(hsfd_pkg::MODE_CAPTURE, lo, cyc, 1'b1);
    endtask

    task automatic queue_frame(frame_kind_t k);
        logic [7:0]  b[4];
        logic [7:0]  sum;
        logic [39:0] fr;
        int          cut;
        if (k == FR_NOISE)
        begin
            repeat ($urandom_range(4, 1))
                queue_capture(hsfd_pkg::mode_t'($urandom_range(3, 1)),
                              $urandom_range(65535, 0), $urandom_range(65535, 0), 1'b0);
        end
        else
        begin
            queue_capture(hsfd_pkg::MODE_START, $urandom_range(65535, 0),
                          $urandom_range(65535, 0), 1'b1);
            if (k == FR_NO_RESP)
                queue_capture(hsfd_pkg::MODE_CAPTURE, $urandom_range(65535, 0), 0, 1'b1);
            else if (k == FR_BAD_RESP)
                queue_response(1'b0);
            else if (k == FR_TIMEOUT)
            begin
                cut = $urandom_range(41, 0);
                if (cut > 0)
                    queue_response(1'b1);
                for (int i = 0; i < cut - 1; i++)
                    queue_bit(i, 1'($urandom_range(1, 0)));
                queue_capture(hsfd_pkg::MODE_TIMEOUT, $urandom_range(65535, 0),
                              $urandom_range(65535, 0), 1'b1);
            end
            else
            begin
                if (k == FR_RESTART)
                begin
                    // abandon a partial frame with a fresh start
                    queue_response(1'b1);
                    cut = $urandom_range(39, 0);
                    for (int i = 0; i < cut; i++)
                        queue_bit(i, 1'($urandom_range(1, 0)));
                    queue_capture(hsfd_pkg::MODE_START, 0, 0, 1'b1);
                end
                queue_response(1'b1);
                if (k == FR_BAD_BIT)
                begin
                    cut = $urandom_range(39, 0);
                    for (int i = 0; i < cut; i++)
                        queue_bit(i, 1'($urandom_range(1, 0)));
                    queue_bad_bit(cut);
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                        b[i] = 8'($urandom_range(255, 0));
                    case ($urandom_range(4, 0))
                        1:
                        begin
                            b[1] = 8'h00;
                            b[3] = 8'h00;
                        end
                        2:
                        begin
                            b[2] = 8'h80;
                            b[3] = 8'h00;
                        end
                        3: for (int i = 0; i < 4; i++) b[i] = 8'hff;
                        4: b[2][7] = 1'b1;
                        default: ;
                    endcase
                    sum = b[0] + b[1] + b[2] + b[3];
                    if (k == FR_BAD_SUM)
                        sum = sum ^ 8'($urandom_range(255, 1));
                    fr = {b[0], b[1], b[2], b[3], sum};
                    for (int i = 0; i < hsfd_pkg::FRAME_BITS; i++)
                        queue_bit(i, fr[hsfd_pkg::FRAME_BITS - 1 - i]);
                end
            end
        end
    endtask

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(99, 0);
        if (r < 40) return FR_GOOD;
        if (r < 50) return FR_BAD_SUM;
        if (r < 65) return FR_BAD_BIT;
        if (r < 75) return FR_TIMEOUT;
        if (r < 80) return FR_NO_RESP;
        if (r < 85) return FR_BAD_RESP;
        if (r < 95) return FR_RESTART;
        return FR_NOISE;
    endfunction

    task automatic wait_idle();
        while (capture_q.size() != 0 || cap.valid || reading_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_frames(int budget);
        int start;
        start = items_queued;
        while (items_queued - start < budget)
            queue_frame(pick_kind());
        wait_idle();
    endtask

    task automatic write_reg(hsfd_pkg::cfg_reg_t idx, int val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = 10'(val);
        nom[idx] = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_nominals(int resp, int byte_lo, int bit_lo, int zero_hi, int one_hi);
        write_reg(hsfd_pkg::REG_RESPONSE_NOMINAL, resp);
        write_reg(hsfd_pkg::REG_BYTE_START_LOW, byte_lo);
        write_reg(hsfd_pkg::REG_BIT_START_LOW, bit_lo);
        write_reg(hsfd_pkg::REG_ZERO_HIGH, zero_hi);
        write_reg(hsfd_pkg::REG_ONE_HIGH, one_hi);
    endtask

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cap.valid = 1'b0;
        cap.mode = '0;
        cap.low_width = '0;
        cap.cycle_width = '0;
        rdg.ready = 1'b0;
        items_queued = 0;
        readings_seen = 0;
        mismatches = 0;
        holds_asked = 0;
        holds_served = 0;
        nom[hsfd_pkg::REG_RESPONSE_NOMINAL] = hsfd_pkg::RESPONSE_NOMINAL_RST;
        nom[hsfd_pkg::REG_BYTE_START_LOW] = hsfd_pkg::BYTE_START_LOW_RST;
        nom[hsfd_pkg::REG_BIT_START_LOW] = hsfd_pkg::BIT_START_LOW_RST;
        nom[hsfd_pkg::REG_ZERO_HIGH] = hsfd_pkg::ZERO_HIGH_RST;
        nom[hsfd_pkg::REG_ONE_HIGH] = hsfd_pkg::ONE_HIGH_RST;
        dec_phase = hsfd_pkg::PH_IDLE;
        dec_bits = 0;
        dec_frame = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle inputs, ignored mode, overflow, short period, overlap, restart
        queue_capture(hsfd_pkg::MODE_CAPTURE, 0, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_TIMEOUT, 16'hffff, 16'hffff, 1'b1);
        queue_capture(hsfd_pkg::MODE_NONE, 16'hffff, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_START, 0, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_NONE, 1234, 5678, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 80, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_START, 16'hffff, 16'hffff, 1'b1);
        queue_capture(hsfd_pkg::MODE_TIMEOUT, 0, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_START, 0, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_START, 0, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 16'hffff, 16'hffff, 1'b1);
        queue_capture(hsfd_pkg::MODE_START, 0, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 80, 160, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 50, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_START, 0, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 80, 160, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 50, 86, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 60, 30, 1'b1);
        queue_capture(hsfd_pkg::MODE_START, 0, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 0, 16'hffff, 1'b1);
        queue_capture(hsfd_pkg::MODE_START, 0, 0, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 80, 160, 1'b1);
        queue_capture(hsfd_pkg::MODE_CAPTURE, 50, 120, 1'b1);
        queue_capture(hsfd_pkg::MODE_TIMEOUT, 0, 0, 1'b1);
        wait_idle();

        // long receiver hold while short frames keep arriving
        holds_asked++;
        repeat (3) queue_frame(FR_TIMEOUT);
        run_frames(80);

        set_nominals(1023, 1023, 1023, 1023, 1023);
        run_frames(60);
        set_nominals(1, 1, 1, 1, 1);
        run_frames(50);
        repeat (4)
        begin
            set_nominals($urandom_range(12, 1), $urandom_range(12, 1), $urandom_range(12, 1),
                         $urandom_range(12, 1), $urandom_range(12, 1));
            run_frames(40);
        end
        repeat (2)
        begin
            set_nominals($urandom_range(1023, 1), $urandom_range(1023, 1),
                         $urandom_range(1023, 1), $urandom_range(1023, 1),
                         $urandom_range(1023, 1));
            holds_asked++;
            run_frames(80);
        end
        // zero and one windows overlap widely
        set_nominals(80, 60, 50, 60, 70);
        run_frames(60);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
